/* rtl/core/bes_pkg.sv */
// bes_pkg: shared widths, action codes and transaction types of the
// bidirectional exponential smoother; used by every file under rtl/core
`timescale 1ns / 1ps
`default_nettype none

package bes_pkg;

  localparam int LINE_LEN   = 1024;
  localparam int IDX_W      = $clog2(LINE_LEN);
  localparam int SAMPLE_W   = 16;
  localparam int WEIGHT_W   = 16;
  localparam int DECAY_W    = 16;
  localparam int VALUE_W    = 24;
  localparam int TOTAL_W    = WEIGHT_W + 1;
  localparam int DIVIDEND_W = 42;
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int ONE_Q16    = 65536;
  localparam int ROUND_HALF = 32768;
  localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd32768;

  localparam logic [1:0] ACT_FWD_ADD = 2'd0;
  localparam logic [1:0] ACT_BWD_ADD = 2'd1;
  localparam logic [1:0] ACT_READ    = 2'd2;
  localparam logic [1:0] ACT_RESTART = 2'd3;

  typedef struct packed {
    logic [1:0]          action;
    logic [9:0]          position;
    logic [SAMPLE_W-1:0] sample_value;
    logic [WEIGHT_W-1:0] sample_weight;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] blended_value;
    logic [TOTAL_W-1:0] total_weight;
  } out_item_t;

  // decoded command as it sits in the front queue
  typedef struct packed {
    logic                is_add;
    logic                is_bwd;
    logic                is_restart;
    logic [IDX_W-1:0]    position;
    logic [SAMPLE_W-1:0] sample;
    logic [WEIGHT_W-1:0] weight;
  } cmd_t;

  typedef struct packed {
    logic cmd_pop;
    logic init_clear;
  } back_status_t;

  typedef struct packed {
    logic                vld;
    logic [VALUE_W-1:0]  value;
    logic [WEIGHT_W-1:0] weight;
  } entry_t;

endpackage

`default_nettype wire

/* rtl/core/bidirectional_exponential_smoother.sv */
// bidirectional_exponential_smoother: top level, front decoder and command
// queue feeding the execution back end; uses bes_pkg, bes_front, bes_back
//
// usage: input transactions enter through in_push/in_full with in_data;
// a transaction is taken on a rising edge with in_push high and in_full low.
// each transaction produces one result on out_data, valid while out_empty is
// low and taken on a rising edge with out_pop high. cfg_wr_en/cfg_wr_data
// write the decay factor; write it only while the block is idle.
// an add leaves the queue in S_IDLE and runs through S_MUL, S_ACC, S_RD,
// S_WMUL, S_SUM, S_DIV and S_OUT; a read goes from S_IDLE to S_RD, and S_DIV
// is skipped when the summed weight at the index is zero. a restart runs the
// store sweep, then S_OUT. S_DIV waits on the bit-serial divider (24 steps
// and a done strobe). one transaction is executed at a time: the next starts
// only once the last result is popped. a two-entry command queue takes
// further transactions while a result waits, so in_full rises only once it
// fills. after reset the line stores are swept over all 1024 entries with
// in_full high; a restart runs the same sweep. when the receiver stalls, the
// result holds and execution pauses until it is popped.
`timescale 1ns / 1ps
`default_nettype none

module bidirectional_exponential_smoother (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_push,
  output logic                           in_full,
  input  wire bes_pkg::in_item_t         in_data,
  output logic                           out_empty,
  input  wire                            out_pop,
  output bes_pkg::out_item_t             out_data,
  input  wire                            cfg_wr_en,
  input  wire  [bes_pkg::DECAY_W-1:0]    cfg_wr_data
);

  bes_pkg::back_status_t status;
  bes_pkg::cmd_t         cmd;
  logic                  cmd_valid;
  logic                  res_valid;

  bes_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .status    (status),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  bes_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .status      (status),
    .res_valid   (res_valid),
    .res_pop     (out_pop),
    .res         (out_data)
  );

  assign out_empty = !res_valid;

endmodule

`default_nettype wire

/* rtl/core/bes_front.sv */
// bes_front: accepts input transactions, decodes the action and holds
// decoded commands in a short queue for the back end; uses bes_pkg
`timescale 1ns / 1ps
`default_nettype none

module bes_front (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_push,
  output logic                       in_full,
  input  wire bes_pkg::in_item_t     in_data,
  input  wire bes_pkg::back_status_t status,
  output logic                       cmd_valid,
  output bes_pkg::cmd_t              cmd
);

  bes_pkg::cmd_t queue_r [bes_pkg::CMDQ_DEPTH];
  logic [bes_pkg::CMDQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [bes_pkg::CMDQ_PTR_W:0]   count_r, count_nxt;
  bes_pkg::cmd_t dec;
  logic push_ok;
  logic pop_ok;

  always_comb begin
    dec.is_add     = 1'b0;
    dec.is_bwd     = 1'b0;
    dec.is_restart = 1'b0;
    dec.position   = bes_pkg::IDX_W'(in_data.position);
    dec.sample     = in_data.sample_value;
    dec.weight     = in_data.sample_weight;
    case (in_data.action)
      bes_pkg::ACT_FWD_ADD: begin
        dec.is_add = 1'b1;
      end
      bes_pkg::ACT_BWD_ADD: begin
        dec.is_add = 1'b1;
        dec.is_bwd = 1'b1;
      end
      bes_pkg::ACT_READ: begin
        dec.is_add = 1'b0;
      end
      bes_pkg::ACT_RESTART: begin
        dec.is_restart = 1'b1;
      end
      default: begin
        dec.is_add = 1'b0;
      end
    endcase
  end

  // no transactions taken while the stores are cleared after reset
  assign in_full   = (count_r == (bes_pkg::CMDQ_PTR_W + 1)'(bes_pkg::CMDQ_DEPTH))
                     || status.init_clear;
  assign push_ok   = in_push && !in_full;
  assign cmd_valid = (count_r != '0);
  assign pop_ok    = status.cmd_pop && cmd_valid;
  assign cmd       = queue_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push_ok && !pop_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push_ok) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      queue_r[wr_ptr_r] <= dec;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/bes_div.sv */
// bes_div: restoring divider, one quotient bit per cycle, for the
// weighted mean; uses bes_pkg
`timescale 1ns / 1ps
`default_nettype none

module bes_div (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                start,
  input  wire  [bes_pkg::DIVIDEND_W-1:0]     dividend,
  input  wire  [bes_pkg::TOTAL_W-1:0]        divisor,
  output logic                               busy,
  output logic                               done,
  output logic [bes_pkg::VALUE_W-1:0]        quotient
);

  localparam int CNT_W = $clog2(bes_pkg::VALUE_W);

  logic                          busy_r, done_r;
  logic [CNT_W-1:0]              cnt_r;
  logic [bes_pkg::TOTAL_W-1:0]   rem_r, dsr_r;
  logic [bes_pkg::VALUE_W-1:0]   quo_r;
  logic [bes_pkg::TOTAL_W:0]     trial;
  logic                          ge;

  assign trial = {rem_r, quo_r[bes_pkg::VALUE_W-1]};
  assign ge    = (trial >= {1'b0, dsr_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(bes_pkg::VALUE_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // the mean never exceeds the largest value, so the upper dividend bits
  // are already below the divisor
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[bes_pkg::VALUE_W +: bes_pkg::TOTAL_W];
      quo_r <= dividend[bes_pkg::VALUE_W-1:0];
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? bes_pkg::TOTAL_W'(trial - {1'b0, dsr_r})
                  : trial[bes_pkg::TOTAL_W-1:0];
      quo_r <= {quo_r[bes_pkg::VALUE_W-2:0], ge};
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

/* rtl/core/bes_back.sv */
// bes_back: executes decoded commands: running averages, the two line
// stores with their clearing sweep, and the weighted mean; uses bes_pkg, bes_div
`timescale 1ns / 1ps
`default_nettype none

module bes_back (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_wr_en,
  input  wire  [bes_pkg::DECAY_W-1:0]      cfg_wr_data,
  input  wire                              cmd_valid,
  input  wire bes_pkg::cmd_t               cmd,
  output bes_pkg::back_status_t            status,
  output logic                             res_valid,
  input  wire                              res_pop,
  output bes_pkg::out_item_t               res
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_ACC   = 4'd3;
  localparam logic [3:0] S_RD    = 4'd4;
  localparam logic [3:0] S_WMUL  = 4'd5;
  localparam logic [3:0] S_SUM   = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  localparam int VW = bes_pkg::VALUE_W;
  localparam int WW = bes_pkg::WEIGHT_W;
  localparam int DW = bes_pkg::DIVIDEND_W;
  localparam logic [bes_pkg::IDX_W-1:0] LAST_IDX = bes_pkg::IDX_W'(bes_pkg::LINE_LEN - 1);

  logic [3:0]                   state_r, state_nxt;
  logic [bes_pkg::DECAY_W-1:0]  decay_r;
  logic [VW-1:0]                fwd_run_r, bwd_run_r;
  logic [bes_pkg::IDX_W-1:0]    clr_addr_r;
  logic                         restart_r;
  bes_pkg::cmd_t                cur_r;

  logic [bes_pkg::SAMPLE_W+16:0] prod_a_r;
  logic [VW+15:0]                prod_b_r;
  bes_pkg::entry_t               fwd_rd_r, bwd_rd_r;
  logic [VW+WW-1:0]              wp1_r, wp2_r;
  logic [bes_pkg::TOTAL_W-1:0]   wsum_r;
  logic [VW-1:0]                 res_value_r;
  logic [bes_pkg::TOTAL_W-1:0]   res_weight_r;

  bes_pkg::entry_t fwd_mem [bes_pkg::LINE_LEN];
  bes_pkg::entry_t bwd_mem [bes_pkg::LINE_LEN];

  logic [VW-1:0]             run_sel;
  logic [16:0]               comp;
  logic [DW-1:0]             acc;
  logic [DW-17:0]            acc_sh;
  logic [VW-1:0]             new_run;
  logic [VW-1:0]             v1, v2;
  logic [WW-1:0]             w1, w2;
  logic [DW-1:0]             num;
  logic                      fwd_we, bwd_we, mem_rd;
  logic [bes_pkg::IDX_W-1:0] wr_addr;
  bes_pkg::entry_t           wr_entry;
  logic                      cmd_pop;
  logic                      div_start, div_busy, div_done;
  logic [VW-1:0]             div_quo;

  assign run_sel = cur_r.is_bwd ? bwd_run_r : fwd_run_r;
  assign comp    = 17'(bes_pkg::ONE_Q16) - 17'(decay_r);

  // (comp * (sample << 8) + d * run + half) >> 16, clamped to 24 bits
  assign acc     = DW'({prod_a_r, 8'b0}) + DW'(prod_b_r) + DW'(bes_pkg::ROUND_HALF);
  assign acc_sh  = acc[DW-1:16];
  assign new_run = (|acc_sh[DW-17:VW]) ? '1 : acc_sh[VW-1:0];

  // unmarked pass counts as value and weight zero
  assign v1 = fwd_rd_r.vld ? fwd_rd_r.value  : '0;
  assign w1 = fwd_rd_r.vld ? fwd_rd_r.weight : '0;
  assign v2 = bwd_rd_r.vld ? bwd_rd_r.value  : '0;
  assign w2 = bwd_rd_r.vld ? bwd_rd_r.weight : '0;
  assign num = DW'(wp1_r) + DW'(wp2_r) + DW'(wsum_r[bes_pkg::TOTAL_W-1:1]);

  assign fwd_we  = (state_r == S_CLEAR) || ((state_r == S_ACC) && !cur_r.is_bwd);
  assign bwd_we  = (state_r == S_CLEAR) || ((state_r == S_ACC) && cur_r.is_bwd);
  assign mem_rd  = (state_r == S_RD);
  assign wr_addr = (state_r == S_CLEAR) ? clr_addr_r : cur_r.position;

  always_comb begin
    wr_entry = '0;
    if (state_r != S_CLEAR) begin
      wr_entry.vld    = 1'b1;
      wr_entry.value  = new_run;
      wr_entry.weight = cur_r.weight;
    end
  end

  assign cmd_pop   = (state_r == S_IDLE) && cmd_valid;
  assign div_start = (state_r == S_SUM) && (wsum_r != '0);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_addr_r == LAST_IDX) begin
          state_nxt = restart_r ? S_OUT : S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid) begin
          if (cmd.is_restart) begin
            state_nxt = S_CLEAR;
          end else if (cmd.is_add) begin
            state_nxt = S_MUL;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_MUL:  state_nxt = S_ACC;
      S_ACC:  state_nxt = S_RD;
      S_RD:   state_nxt = S_WMUL;
      S_WMUL: state_nxt = S_SUM;
      S_SUM:  state_nxt = (wsum_r == '0) ? S_OUT : S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (res_pop) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_addr_r <= '0;
      restart_r  <= 1'b0;
      decay_r    <= bes_pkg::DECAY_RESET;
      fwd_run_r  <= '0;
      bwd_run_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        decay_r <= cfg_wr_data;
      end
      if (state_r == S_CLEAR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == LAST_IDX) begin
          restart_r <= 1'b0;
        end
      end
      if (cmd_pop && cmd.is_restart) begin
        clr_addr_r <= '0;
        restart_r  <= 1'b1;
        fwd_run_r  <= '0;
        bwd_run_r  <= '0;
      end
      if (state_r == S_ACC) begin
        if (cur_r.is_bwd) begin
          bwd_run_r <= new_run;
        end else begin
          fwd_run_r <= new_run;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur_r <= cmd;
    end
    if (state_r == S_MUL) begin
      prod_a_r <= comp * cur_r.sample;
      prod_b_r <= decay_r * run_sel;
    end
    if (state_r == S_WMUL) begin
      wp1_r  <= w1 * v1;
      wp2_r  <= w2 * v2;
      wsum_r <= bes_pkg::TOTAL_W'(w1) + bes_pkg::TOTAL_W'(w2);
    end
    if ((state_r == S_CLEAR) && (clr_addr_r == LAST_IDX)) begin
      res_value_r  <= '0;
      res_weight_r <= '0;
    end
    if (state_r == S_SUM) begin
      res_value_r  <= '0;
      res_weight_r <= wsum_r;
    end
    if ((state_r == S_DIV) && div_done) begin
      res_value_r <= div_quo;
    end
  end

  // line stores, one write port and one registered read port each
  always_ff @(posedge clk) begin
    if (fwd_we) begin
      fwd_mem[wr_addr] <= wr_entry;
    end
    if (mem_rd) begin
      fwd_rd_r <= fwd_mem[cur_r.position];
    end
  end

  always_ff @(posedge clk) begin
    if (bwd_we) begin
      bwd_mem[wr_addr] <= wr_entry;
    end
    if (mem_rd) begin
      bwd_rd_r <= bwd_mem[cur_r.position];
    end
  end

  bes_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (num),
    .divisor  (wsum_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign status.cmd_pop    = cmd_pop;
  assign status.init_clear = (state_r == S_CLEAR) && !restart_r;
  assign res_valid         = (state_r == S_OUT);
  assign res.blended_value = res_value_r;
  assign res.total_weight  = res_weight_r;

  a_zero_weight_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && (res_weight_r == '0) |-> (res_value_r == '0))
    else $error("nonzero mean with zero total weight");

  a_div_not_restarted: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_restart_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) && ($past(state_r) == S_CLEAR) |-> (res_weight_r == '0))
    else $error("restart transaction answered with nonzero weight");

  a_pop_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_valid && (state_r == S_IDLE) && !res_valid)
    else $error("command taken while back end busy");

endmodule

`default_nettype wire

/* bench/testbench.sv */
// testbench: self-checking bench for bidirectional_exponential_smoother, a directed
// table followed by random line passes, results scored by table or in-bench predictor
// depends on bes_pkg and the sources under rtl/core
`timescale 1ns / 1ps

module testbench;

  localparam int QUIET_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_ITEMS   = 120;
  localparam int SHOW_LIMIT    = 10;

  typedef struct {
    bes_pkg::in_item_t  item;
    bit                 typed;
    bes_pkg::out_item_t want;
  } dir_row_t;

  logic                        clk;
  logic                        rst_n;
  logic                        in_push;
  logic                        in_full;
  bes_pkg::in_item_t           in_data;
  logic                        out_empty;
  logic                        out_pop;
  bes_pkg::out_item_t          out_data;
  logic                        cfg_wr_en;
  logic [bes_pkg::DECAY_W-1:0] cfg_wr_data;

  // predictor copy of the smoother state
  logic [bes_pkg::DECAY_W-1:0]  cur_decay;
  logic [bes_pkg::VALUE_W-1:0]  fwd_run;
  logic [bes_pkg::VALUE_W-1:0]  bwd_run;
  logic [bes_pkg::VALUE_W-1:0]  fwd_val [bes_pkg::LINE_LEN];
  logic [bes_pkg::WEIGHT_W-1:0] fwd_wt  [bes_pkg::LINE_LEN];
  logic [bes_pkg::VALUE_W-1:0]  bwd_val [bes_pkg::LINE_LEN];
  logic [bes_pkg::WEIGHT_W-1:0] bwd_wt  [bes_pkg::LINE_LEN];
  logic [1:0]                   pass_marks [bes_pkg::LINE_LEN];

  bes_pkg::out_item_t smoothed_q[$];

  int send_idle_pct;
  int recv_idle_pct;
  bit hold_req;
  int errors;
  int items_sent;
  int restarts_sent;
  int results_seen;
  int full_stalls;
  int decay_writes;

  bidirectional_exponential_smoother DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_data     (in_data),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin : clock_gen
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [bes_pkg::VALUE_W-1:0] next_running(
      logic [bes_pkg::VALUE_W-1:0] run, logic [bes_pkg::SAMPLE_W-1:0] s);
    logic [63:0] acc;
    acc = (64'(bes_pkg::ONE_Q16) - 64'(cur_decay)) * 64'({s, 8'd0})
        + 64'(cur_decay) * 64'(run) + 64'(bes_pkg::ROUND_HALF);
    acc = acc >> 16;
    if (acc > 64'hFF_FFFF) acc = 64'hFF_FFFF;
    return acc[bes_pkg::VALUE_W-1:0];
  endfunction

  // applies one transaction to the predictor state and returns its result
  function automatic bes_pkg::out_item_t smooth_item(bes_pkg::in_item_t it);
    bes_pkg::out_item_t r;
    logic [63:0]        v1, w1, v2, w2, wsum, num, q;
    int                 p;
    p = int'(it.position);
    case (it.action)
      bes_pkg::ACT_FWD_ADD: begin
        fwd_run = next_running(fwd_run, it.sample_value);
        fwd_val[p] = fwd_run;
        fwd_wt[p] = it.sample_weight;
        pass_marks[p][0] = 1'b1;
      end
      bes_pkg::ACT_BWD_ADD: begin
        bwd_run = next_running(bwd_run, it.sample_value);
        bwd_val[p] = bwd_run;
        bwd_wt[p] = it.sample_weight;
        pass_marks[p][1] = 1'b1;
      end
      bes_pkg::ACT_READ: ;
      bes_pkg::ACT_RESTART: begin
        fwd_run = '0;
        bwd_run = '0;
        foreach (pass_marks[i]) pass_marks[i] = 2'b00;
      end
    endcase
    v1 = 0;
    w1 = 0;
    v2 = 0;
    w2 = 0;
    if (pass_marks[p][0]) begin
      v1 = 64'(fwd_val[p]);
      w1 = 64'(fwd_wt[p]);
    end
    if (pass_marks[p][1]) begin
      v2 = 64'(bwd_val[p]);
      w2 = 64'(bwd_wt[p]);
    end
    wsum = w1 + w2;
    q = 0;
    if (wsum != 0) begin
      num = w1 * v1 + w2 * v2;
      q = (num + (wsum >> 1)) / wsum;
      if (q > 64'hFF_FFFF) q = 64'hFF_FFFF;
    end
    r.blended_value = q[bes_pkg::VALUE_W-1:0];
    r.total_weight = wsum[bes_pkg::TOTAL_W-1:0];
    return r;
  endfunction

  function automatic dir_row_t row(logic [1:0] act, int pos, int smp, int wgt,
                                   bit typed, int val, int tot);
    dir_row_t r;
    r.item.action = act;
    r.item.position = pos[bes_pkg::IDX_W-1:0];
    r.item.sample_value = smp[bes_pkg::SAMPLE_W-1:0];
    r.item.sample_weight = wgt[bes_pkg::WEIGHT_W-1:0];
    r.typed = typed;
    r.want.blended_value = val[bes_pkg::VALUE_W-1:0];
    r.want.total_weight = tot[bes_pkg::TOTAL_W-1:0];
    return r;
  endfunction

  // random 16-bit field that lands on the extremes now and then
  function automatic logic [15:0] field16();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return 16'h0000;
    if (pick == 1) return 16'hFFFF;
    return 16'($urandom_range(16'hFFFF));
  endfunction

  function automatic bes_pkg::in_item_t make_item(logic [1:0] act, int pos);
    bes_pkg::in_item_t it;
    it.action = act;
    it.position = pos[bes_pkg::IDX_W-1:0];
    it.sample_value = field16();
    it.sample_weight = field16();
    return it;
  endfunction

  task automatic offer(bes_pkg::in_item_t it, bit typed, bes_pkg::out_item_t want);
    bes_pkg::out_item_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_full) begin
      full_stalls++;
      @(posedge clk);
    end
    predicted = smooth_item(it);
    smoothed_q.push_back(typed ? want : predicted);
    items_sent++;
    if (it.action == bes_pkg::ACT_RESTART) restarts_sent++;
  endtask

  task automatic score_result(bes_pkg::out_item_t got);
    bes_pkg::out_item_t want;
    results_seen++;
    if (smoothed_q.size() == 0) begin
      errors++;
      if (errors <= SHOW_LIMIT)
        $display("%0t: result with nothing expected: blended_value %h total_weight %h",
                 $realtime, got.blended_value, got.total_weight);
    end else begin
      want = smoothed_q.pop_front();
      if (got.blended_value !== want.blended_value ||
          got.total_weight !== want.total_weight) begin
        errors++;
        if (errors <= SHOW_LIMIT)
          $display("%0t: mismatch blended_value exp %h got %h, total_weight exp %h got %h",
                   $realtime, want.blended_value, got.blended_value,
                   want.total_weight, got.total_weight);
      end
    end
  endtask

  // waits for the block to go idle, then writes the decay factor
  task automatic set_decay(logic [bes_pkg::DECAY_W-1:0] val);
    in_push <= 1'b0;
    while (smoothed_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_decay = val;
    decay_writes++;
  endtask

  task automatic random_phase(int n);
    int first;
    int pick;
    int span;
    int base;
    first = items_sent;
    while (items_sent - first < n) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        // forward pass, backward pass, then read back the same stretch
        span = $urandom_range(2, 12);
        pick = $urandom_range(9);
        if (pick == 0) base = bes_pkg::LINE_LEN - span;
        else if (pick < 5) base = $urandom_range(0, 40);
        else base = $urandom_range(0, bes_pkg::LINE_LEN - span);
        for (int k = 0; k < span; k++)
          offer(make_item(bes_pkg::ACT_FWD_ADD, base + k), 1'b0, '0);
        // now and then the backward pass is left out
        if ($urandom_range(9) != 0)
          for (int k = span - 1; k >= 0; k--)
            offer(make_item(bes_pkg::ACT_BWD_ADD, base + k), 1'b0, '0);
        for (int k = 0; k < span; k++)
          offer(make_item(bes_pkg::ACT_READ, base + k), 1'b0, '0);
      end else if (pick < 73) begin
        offer(make_item(bes_pkg::ACT_RESTART, $urandom_range(bes_pkg::LINE_LEN - 1)),
              1'b0, '0);
      end else begin
        offer(make_item(2'($urandom_range(3)), $urandom_range(bes_pkg::LINE_LEN - 1)),
              1'b0, '0);
      end
    end
  endtask

  initial begin : result_side
    int hold_left;
    hold_left = 0;
    out_pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) score_result(out_data);
      if (hold_left > 0) begin
        out_pop <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        // long hold-off so the input side backs up
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
    $display("bidirectional_exponential_smoother test failed");
    $finish;
  end

  initial begin : stimulus
    dir_row_t                    dir_tab[$];
    logic [bes_pkg::DECAY_W-1:0] decay_plan [5];
    rst_n <= 1'b0;
    in_push <= 1'b0;
    in_data <= '0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    hold_req = 1'b0;
    errors = 0;
    items_sent = 0;
    restarts_sent = 0;
    results_seen = 0;
    full_stalls = 0;
    decay_writes = 0;
    cur_decay = bes_pkg::DECAY_RESET;
    fwd_run = '0;
    bwd_run = '0;
    foreach (pass_marks[i]) begin
      pass_marks[i] = 2'b00;
      fwd_val[i] = '0;
      fwd_wt[i] = '0;
      bwd_val[i] = '0;
      bwd_wt[i] = '0;
    end
    send_idle_pct = 27;
    recv_idle_pct = 88;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows run with the reset decay of one half
    dir_tab.push_back(row(bes_pkg::ACT_READ,    0,    0,      0,      1, 0,        0));
    dir_tab.push_back(row(bes_pkg::ACT_FWD_ADD, 0,    'hFFFF, 'hFFFF, 1, 'h7FFF80, 'hFFFF));
    dir_tab.push_back(row(bes_pkg::ACT_BWD_ADD, 0,    0,      0,      0, 0,        0));
    dir_tab.push_back(row(bes_pkg::ACT_BWD_ADD, 1023, 'hFFFF, 'hFFFF, 0, 0,        0));
    dir_tab.push_back(row(bes_pkg::ACT_FWD_ADD, 1023, 'h1234, 'h8000, 0, 0,        0));
    dir_tab.push_back(row(bes_pkg::ACT_READ,    1023, 0,      0,      0, 0,        0));
    dir_tab.push_back(row(bes_pkg::ACT_READ,    512,  'hFFFF, 'hFFFF, 1, 0,        0));
    // both passes with zero weight give a zero blend
    dir_tab.push_back(row(bes_pkg::ACT_FWD_ADD, 5,    'hABCD, 0,      1, 0,        0));
    dir_tab.push_back(row(bes_pkg::ACT_BWD_ADD, 5,    0,      0,      1, 0,        0));
    dir_tab.push_back(row(bes_pkg::ACT_FWD_ADD, 6,    'h5555, 'h0001, 0, 0,        0));
    dir_tab.push_back(row(bes_pkg::ACT_BWD_ADD, 6,    'hAAAA, 'hFFFF, 0, 0,        0));
    dir_tab.push_back(row(bes_pkg::ACT_READ,    6,    0,      0,      0, 0,        0));
    dir_tab.push_back(row(bes_pkg::ACT_FWD_ADD, 7,    'hFFFF, 'hFFFF, 0, 0,        0));
    dir_tab.push_back(row(bes_pkg::ACT_BWD_ADD, 7,    0,      'hFFFF, 0, 0,        0));
    dir_tab.push_back(row(bes_pkg::ACT_RESTART, 0,    'hFFFF, 'hFFFF, 1, 0,        0));
    // after the restart no pass is marked, so these reads give zero
    dir_tab.push_back(row(bes_pkg::ACT_READ,    0,    0,      0,      1, 0,        0));
    dir_tab.push_back(row(bes_pkg::ACT_READ,    1023, 0,      0,      1, 0,        0));
    dir_tab.push_back(row(bes_pkg::ACT_FWD_ADD, 1023, 0,      'hFFFF, 1, 0,        'hFFFF));
    dir_tab.push_back(row(bes_pkg::ACT_RESTART, 1023, 0,      0,      1, 0,        0));
    dir_tab.push_back(row(bes_pkg::ACT_FWD_ADD, 341,  'h8000, 'h5555, 0, 0,        0));
    dir_tab.push_back(row(bes_pkg::ACT_BWD_ADD, 682,  'h7FFF, 'hAAAA, 0, 0,        0));
    dir_tab.push_back(row(bes_pkg::ACT_READ,    341,  0,      0,      0, 0,        0));
    foreach (dir_tab[i]) offer(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);

    decay_plan[0] = '0;
    decay_plan[1] = '1;
    decay_plan[2] = 16'd1;
    decay_plan[3] = 16'($urandom_range(2, 65534));
    decay_plan[4] = bes_pkg::DECAY_RESET;
    for (int ph = 0; ph < 5; ph++) begin
      set_decay(decay_plan[ph]);
      if (ph == 2) begin
        send_idle_pct = 88;
        recv_idle_pct = 27;
      end else if (ph == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (ph == 0 || ph == 4) hold_req = 1'b1;
      random_phase(PHASE_ITEMS);
    end
    in_push <= 1'b0;

    while (smoothed_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    errors += smoothed_q.size();
    $display("covered %0d input transactions (%0d restarts), %0d decay settings, %0d results",
             items_sent, restarts_sent, decay_writes + 1, results_seen);
    $display("input held back for %0d cycles, %0d mismatches", full_stalls, errors);
    if (errors == 0) begin
      $display("bidirectional_exponential_smoother test passed");
    end else begin
      $display("bidirectional_exponential_smoother test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/bes_pkg.sv
rtl/core/bes_front.sv
rtl/core/bes_div.sv
rtl/core/bes_back.sv
rtl/core/bidirectional_exponential_smoother.sv
bench/testbench.sv
